>>> rtl/core/gfmi_pkg.sv
// Shared types, constants and helpers for the GF(2^8) multiply / inverse unit.
`default_nettype none

package gfmi_pkg;

  localparam int unsigned ElemW    = 8;
  localparam int unsigned PolyW    = ElemW + 1;
  localparam int unsigned DegW     = $clog2(PolyW);
  localparam int unsigned MulSteps = ElemW;
  localparam int unsigned CntW     = $clog2(MulSteps);

  localparam logic [PolyW-1:0] PolyReset = PolyW'(283);
  localparam logic [PolyW-1:0] PolyTop   = PolyW'(1) << ElemW;

  localparam logic ModeMul = 1'b0;
  localparam logic ModeInv = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StInv,
    StFin
  } state_e;

  // Working registers: remainders r0/r1 and Bezout coefficients s0/s1.
  // Multiply reuses r0 as the shifting multiplier, r1 as the multiplicand
  // and s0 as the accumulator.
  typedef struct packed {
    logic [PolyW-1:0] r0;
    logic [PolyW-1:0] r1;
    logic [PolyW-1:0] s0;
    logic [PolyW-1:0] s1;
  } work_t;

  typedef struct packed {
    logic load;
    logic step_en;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic r1_zero;
  } status_t;

  // Index of the highest set bit; zero input gives zero.
  function automatic logic [DegW-1:0] poly_deg(input logic [PolyW-1:0] x);
    logic [DegW-1:0] d;
    d = '0;
    for (int i = 0; i < PolyW; i++) begin
      if (x[i]) begin
        d = DegW'(i);
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/gfmi_step.sv
// Shared step unit: one multiply iteration or one Euclid division/swap step.
`default_nettype none

module gfmi_step (
  input  logic                          is_mul_i,
  input  logic [gfmi_pkg::ElemW-1:0]    poly_low_i,
  input  gfmi_pkg::work_t               cur_i,
  output gfmi_pkg::work_t               nxt_o
);

  logic [gfmi_pkg::DegW-1:0]  deg0;
  logic [gfmi_pkg::DegW-1:0]  deg1;
  logic [gfmi_pkg::DegW-1:0]  sh;
  logic                       sub;
  logic [gfmi_pkg::ElemW-1:0] acc_nxt;

  assign deg0 = gfmi_pkg::poly_deg(cur_i.r0);
  assign deg1 = gfmi_pkg::poly_deg(cur_i.r1);
  assign sub  = (cur_i.r0 != '0) && (deg0 >= deg1);
  assign sh   = deg0 - deg1;

  // MSB-first shift-and-add with reduction by the low polynomial bits.
  assign acc_nxt = {cur_i.s0[gfmi_pkg::ElemW-2:0], 1'b0}
                 ^ (cur_i.s0[gfmi_pkg::ElemW-1] ? poly_low_i : '0)
                 ^ (cur_i.r0[gfmi_pkg::ElemW-1] ? cur_i.r1[gfmi_pkg::ElemW-1:0] : '0);

  always_comb begin
    nxt_o = cur_i;
    if (is_mul_i) begin
      nxt_o.r0 = {cur_i.r0[gfmi_pkg::ElemW-1:0], 1'b0};
      nxt_o.s0 = {1'b0, acc_nxt};
    end else if (sub) begin
      // cancel the leading term of r0 with a shifted copy of r1
      nxt_o.r0 = cur_i.r0 ^ (cur_i.r1 << sh);
      nxt_o.s0 = cur_i.s0 ^ (cur_i.s1 << sh);
    end else begin
      // quotient finished: remainder becomes the new divisor
      nxt_o.r0 = cur_i.r1;
      nxt_o.r1 = cur_i.r0;
      nxt_o.s0 = cur_i.s1;
      nxt_o.s1 = cur_i.s0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/gfmi_datapath.sv
// Datapath: polynomial register, working registers and result register.
`default_nettype none

module gfmi_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gfmi_pkg::PolyW-1:0]    cfg_wdata_i,
  input  logic                          mode_i,
  input  logic [gfmi_pkg::ElemW-1:0]    operand_a_i,
  input  logic [gfmi_pkg::ElemW-1:0]    operand_b_i,
  input  gfmi_pkg::ctrl_t               ctrl_i,
  output gfmi_pkg::status_t             status_o,
  output logic [gfmi_pkg::ElemW-1:0]    result_o,
  output logic                          no_inverse_o
);

  logic [gfmi_pkg::PolyW-1:0] poly_q;
  logic [gfmi_pkg::PolyW-1:0] poly;
  logic                       mode_q;
  gfmi_pkg::work_t            work_q, work_d, work_step;
  logic [gfmi_pkg::PolyW-1:0] s0_red;
  logic [gfmi_pkg::ElemW-1:0] res_d, result_q;
  logic                       flag_d, flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= gfmi_pkg::PolyReset;
    end else if (cfg_we_i) begin
      poly_q <= cfg_wdata_i;
    end
  end

  // degree is always eight
  assign poly = poly_q | gfmi_pkg::PolyTop;

  gfmi_step u_step (
    .is_mul_i   (mode_q == gfmi_pkg::ModeMul),
    .poly_low_i (poly[gfmi_pkg::ElemW-1:0]),
    .cur_i      (work_q),
    .nxt_o      (work_step)
  );

  always_comb begin
    work_d = work_q;
    if (ctrl_i.load) begin
      if (mode_i == gfmi_pkg::ModeInv) begin
        work_d.r0 = poly;
        work_d.r1 = {1'b0, operand_a_i};
        work_d.s0 = '0;
        work_d.s1 = gfmi_pkg::PolyW'(1);
      end else begin
        work_d.r0 = {1'b0, operand_a_i};
        work_d.r1 = {1'b0, operand_b_i};
        work_d.s0 = '0;
        work_d.s1 = '0;
      end
    end else if (ctrl_i.step_en) begin
      work_d = work_step;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (ctrl_i.load) begin
      mode_q <= mode_i;
    end
  end

  assign status_o.r1_zero = (work_q.r1 == '0);

  // Coefficient may reach degree eight: one conditional subtract reduces it.
  assign s0_red = work_q.s0[gfmi_pkg::ElemW] ? (work_q.s0 ^ poly) : work_q.s0;

  always_comb begin
    res_d  = work_q.s0[gfmi_pkg::ElemW-1:0];
    flag_d = 1'b0;
    if (mode_q == gfmi_pkg::ModeInv) begin
      if (work_q.r0 == gfmi_pkg::PolyW'(1)) begin
        res_d = s0_red[gfmi_pkg::ElemW-1:0];
      end else begin
        res_d  = '0;
        flag_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      result_q <= res_d;
      flag_q   <= flag_d;
    end
  end

  assign result_o     = result_q;
  assign no_inverse_o = flag_q;

endmodule

`default_nettype wire

>>> rtl/core/gfmi_ctrl.sv
// Sequencer: accepts a beat, runs the step unit, hands the result to the output register.
`default_nettype none

module gfmi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  gfmi_pkg::status_t status_i,
  output gfmi_pkg::ctrl_t   ctrl_o
);

  gfmi_pkg::state_e            state_q, state_d;
  logic [gfmi_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_free;
  logic                        mul_last;

  assign out_free = !out_valid_q || out_ready_i;
  assign mul_last = (cnt_q == gfmi_pkg::CntW'(gfmi_pkg::MulSteps - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      gfmi_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = (mode_i == gfmi_pkg::ModeInv) ? gfmi_pkg::StInv : gfmi_pkg::StMul;
        end
      end
      gfmi_pkg::StMul: begin
        if (mul_last) begin
          state_d = gfmi_pkg::StFin;
        end
      end
      gfmi_pkg::StInv: begin
        if (status_i.r1_zero) begin
          state_d = gfmi_pkg::StFin;
        end
      end
      gfmi_pkg::StFin: begin
        if (out_free) begin
          state_d = gfmi_pkg::StIdle;
        end
      end
      default: state_d = gfmi_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    ctrl_o.load     = 1'b0;
    ctrl_o.step_en  = 1'b0;
    ctrl_o.out_load = 1'b0;
    case (state_q)
      gfmi_pkg::StIdle: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      gfmi_pkg::StMul: ctrl_o.step_en = 1'b1;
      gfmi_pkg::StInv: ctrl_o.step_en = !status_i.r1_zero;
      gfmi_pkg::StFin: ctrl_o.out_load = out_free;
      default: ctrl_o.load = 1'b0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_o.load) begin
      cnt_d = '0;
    end else if (state_q == gfmi_pkg::StMul) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gfmi_pkg::StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/core/gf256_multiply_inverse_unit.sv
// Top level of the GF(2^8) multiply / inverse unit.
//
// Input channel (in_valid_i / in_ready_o) carries mode_i, operand_a_i and
// operand_b_i; mode 0 multiplies A by B modulo the field polynomial, mode 1
// returns the inverse of A (0 with no_inverse_o set when none exists).
// Output channel (out_valid_o / out_ready_i) carries result_o and
// no_inverse_o, one beat per input beat, in order.
// cfg_we_i / cfg_wdata_i write the field polynomial; bit 8 is always taken
// as set. Write it only while the unit is idle.
// One shared step unit does all the work, one step per cycle:
//   multiply: accept, 8 shift-and-add steps, then the finish state.
//   inverse: accept, one step per quotient bit and one per remainder swap
//   of the Euclid recursion, a step that sees the zero remainder, then
//   the finish state.
// in_ready_o is high only while the sequencer is idle. The result sits in an
// output register, so the next beat is accepted while a result waits; a
// stalled receiver holds the sequencer in its finish cycle once a second
// result is ready.
// Reset clears the sequencer and output valid and restores polynomial 0x11B.
`default_nettype none

module gf256_multiply_inverse_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gfmi_pkg::PolyW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [gfmi_pkg::ElemW-1:0]    operand_a_i,
  input  logic [gfmi_pkg::ElemW-1:0]    operand_b_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gfmi_pkg::ElemW-1:0]    result_o,
  output logic                          no_inverse_o
);

  gfmi_pkg::ctrl_t   ctrl;
  gfmi_pkg::status_t status;

  gfmi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  gfmi_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mode_i       (mode_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .result_o     (result_o),
    .no_inverse_o (no_inverse_o)
  );

  // not ready in the cycle after each accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_no_inverse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_inverse_o) |-> (result_o == '0))
    else $error("no_inverse flagged with nonzero result");

  // a new result only comes from a busy sequencer
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result produced without work");

endmodule

`default_nettype wire
